// ===== rtl/software_timer_bank_assert.svh =====
// Assertion macros for the software timer bank.
// Checks are active in simulation and drop out when SYNTHESIS is defined.
// Every module that uses them has the clock aclk and the reset aresetn.
`ifndef SOFTWARE_TIMER_BANK_ASSERT_SVH
`define SOFTWARE_TIMER_BANK_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on aclk, with the check off while reset is held.
`define STB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check a property on aclk, also during reset.
`define STB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define STB_ASSERT(label, prop, msg)
`define STB_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/stb_pkg.sv =====
// Shared types and constants of the software timer bank.
// Used by stb_front, stb_back and software_timer_bank.
package stb_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SET     = 2'd1,
        CMD_KILL    = 2'd2,
        CMD_PRIMARY = 2'd3
    } cmd_code_t;

    // One classified item as it waits in the queue
    typedef struct packed {
        cmd_code_t   op;
        logic        refused;
        logic [31:0] now;
        logic [31:0] timer_id;
        logic [31:0] elapse;
        logic        handler;
    } item_t;

    // One table slot
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] interval;
        logic [31:0] last_tick;
        logic        handler;
    } slot_t;

    // One result item
    typedef struct packed {
        logic        fired;
        logic        primary_fired;
        logic [31:0] fired_id;
        logic        ok;
        logic        last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIM,
        ST_READ,
        ST_EVAL,
        ST_WRITE,
        ST_REPLY,
        ST_FINISH
    } back_state_t;

endpackage

// ===== rtl/stb_front.sv =====
// Front end of the software timer bank: accepts and classifies items.
// Holds them in a short queue for stb_back. Depends on stb_pkg.
`include "software_timer_bank_assert.svh"

module stb_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_command,
    input  logic [31:0]         s_now,
    input  logic [31:0]         s_timer_id,
    input  logic [31:0]         s_elapse,
    input  logic                s_has_handler,
    output logic                q_valid,
    output stb_pkg::item_t      q_item,
    input  logic                q_pop
);

    stb_pkg::item_t                  fifo_reg [stb_pkg::QUEUE_DEPTH];
    logic [stb_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [stb_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [stb_pkg::QCNT_W-1:0]      count_reg, count_next;
    stb_pkg::item_t                  in_item;
    logic                            push;
    logic                            pop;

    // Classify the incoming item
    always_comb begin
        in_item.op       = stb_pkg::cmd_code_t'(s_command);
        in_item.refused  = (s_timer_id == 32'd0) && !s_has_handler;
        in_item.now      = s_now;
        in_item.timer_id = s_timer_id;
        in_item.elapse   = s_elapse;
        in_item.handler  = s_has_handler;
    end

    assign s_ready = (count_reg != stb_pkg::QCNT_W'(stb_pkg::QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign pop     = q_pop;
    assign q_valid = (count_reg != '0);
    assign q_item  = fifo_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == stb_pkg::QPTR_W'(stb_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + stb_pkg::QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == stb_pkg::QPTR_W'(stb_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + stb_pkg::QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + stb_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - stb_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

    `STB_ASSERT(a_count_max, count_reg <= stb_pkg::QCNT_W'(stb_pkg::QUEUE_DEPTH), "queue overfilled")
    `STB_ASSERT(a_pop_nonempty, pop |-> (count_reg != '0), "pop from empty queue")
    `STB_ASSERT(a_empty_ptrs, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "empty queue pointers differ")

endmodule

// ===== rtl/stb_back.sv =====
// Back end of the software timer bank: carries out tick, set and kill.
// Walks the slot memory one slot at a time. Depends on stb_pkg.
`include "software_timer_bank_assert.svh"

module stb_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  stb_pkg::item_t      q_item,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output stb_pkg::result_t    m_result
);

    stb_pkg::back_state_t           state_reg, state_next;
    stb_pkg::item_t                 cur_reg, cur_next;
    logic [stb_pkg::SLOT_W-1:0]     idx_reg, idx_next;
    logic [stb_pkg::SLOT_W-1:0]     tgt_reg, tgt_next;
    logic                           found_reg, found_next;
    logic                           reply_ok_reg, reply_ok_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic                           pend_prim_reg, pend_prim_next;
    logic [31:0]                    pend_id_reg, pend_id_next;
    logic [31:0]                    prim_int_reg, prim_int_next;
    logic [31:0]                    prim_last_reg, prim_last_next;
    logic                           prim_en_reg, prim_en_next;
    logic                           out_valid_reg, out_valid_next;
    stb_pkg::result_t               out_reg, out_next;
    logic [stb_pkg::TIMER_SLOTS-1:0] slot_valid_reg;

    stb_pkg::slot_t                 mem [stb_pkg::TIMER_SLOTS];
    stb_pkg::slot_t                 rd_data_reg;
    logic                           rd_valid_reg;
    logic                           mem_we;
    logic [stb_pkg::SLOT_W-1:0]     mem_waddr;
    stb_pkg::slot_t                 mem_wdata;
    logic                           valid_set;
    logic                           valid_clr;

    stb_pkg::slot_t                 entry;
    logic                           out_free;
    logic                           slot_active;
    logic                           went_back;
    logic                           slot_fire;
    logic                           fire_stall;
    logic                           last_slot;
    logic                           id_match;
    logic                           free_hit;
    logic                           prim_back;
    logic                           prim_due;
    logic [31:0]                    slot_age;
    logic [31:0]                    prim_age;

    // Evaluate the slot just read
    assign entry       = rd_valid_reg ? rd_data_reg : '0;
    assign out_free    = !out_valid_reg || m_ready;
    assign slot_age    = cur_reg.now - entry.last_tick;
    assign slot_active = (entry.id != 32'd0) && entry.handler;
    assign went_back   = cur_reg.now < entry.last_tick;
    assign slot_fire   = slot_active && !went_back && (slot_age >= entry.interval);
    assign fire_stall  = (cur_reg.op == stb_pkg::CMD_TICK) && slot_fire
                         && pend_valid_reg && !out_free;
    assign last_slot   = (idx_reg == stb_pkg::SLOT_W'(stb_pkg::TIMER_SLOTS - 1));
    assign id_match    = (entry.id == cur_reg.timer_id);
    assign free_hit    = !found_reg && (entry.id == 32'd0);
    assign prim_age    = cur_reg.now - prim_last_reg;
    assign prim_back   = cur_reg.now < prim_last_reg;
    assign prim_due    = prim_age >= prim_int_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stb_pkg::ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_item.op)
                        stb_pkg::CMD_TICK:    state_next = stb_pkg::ST_PRIM;
                        stb_pkg::CMD_SET:     state_next = q_item.refused ? stb_pkg::ST_REPLY
                                                                          : stb_pkg::ST_READ;
                        stb_pkg::CMD_KILL:    state_next = stb_pkg::ST_READ;
                        stb_pkg::CMD_PRIMARY: state_next = stb_pkg::ST_REPLY;
                        default:              state_next = stb_pkg::ST_REPLY;
                    endcase
                end
            end
            stb_pkg::ST_PRIM: state_next = stb_pkg::ST_READ;
            stb_pkg::ST_READ: state_next = stb_pkg::ST_EVAL;
            stb_pkg::ST_EVAL: begin
                priority if (fire_stall) begin
                    state_next = stb_pkg::ST_EVAL;
                end else if (cur_reg.op == stb_pkg::CMD_SET && id_match) begin
                    state_next = stb_pkg::ST_WRITE;
                end else if (last_slot) begin
                    unique case (cur_reg.op)
                        stb_pkg::CMD_TICK: state_next = stb_pkg::ST_FINISH;
                        stb_pkg::CMD_SET:  state_next = (found_reg || free_hit)
                                                        ? stb_pkg::ST_WRITE
                                                        : stb_pkg::ST_REPLY;
                        default:           state_next = stb_pkg::ST_REPLY;
                    endcase
                end else begin
                    state_next = stb_pkg::ST_READ;
                end
            end
            stb_pkg::ST_WRITE:  state_next = stb_pkg::ST_REPLY;
            stb_pkg::ST_REPLY:  state_next = out_free ? stb_pkg::ST_IDLE : stb_pkg::ST_REPLY;
            stb_pkg::ST_FINISH: state_next = out_free ? stb_pkg::ST_IDLE : stb_pkg::ST_FINISH;
            default:            state_next = stb_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        cur_next        = cur_reg;
        idx_next        = idx_reg;
        tgt_next        = tgt_reg;
        found_next      = found_reg;
        reply_ok_next   = reply_ok_reg;
        pend_valid_next = pend_valid_reg;
        pend_prim_next  = pend_prim_reg;
        pend_id_next    = pend_id_reg;
        prim_int_next   = prim_int_reg;
        prim_last_next  = prim_last_reg;
        prim_en_next    = prim_en_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_next        = out_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = entry;
        valid_set       = 1'b0;
        valid_clr       = 1'b0;
        unique case (state_reg)
            stb_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop           = 1'b1;
                    cur_next        = q_item;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                    reply_ok_next   = 1'b0;
                    if (q_item.op == stb_pkg::CMD_PRIMARY) begin
                        prim_last_next = q_item.now;
                        prim_int_next  = q_item.elapse;
                        prim_en_next   = q_item.handler;
                        reply_ok_next  = 1'b1;
                    end
                end
            end
            stb_pkg::ST_PRIM: begin
                // Check the primary timer ahead of the table
                if (prim_en_reg) begin
                    if (prim_back) begin
                        prim_last_next = cur_reg.now;
                    end else if (prim_due) begin
                        prim_last_next  = cur_reg.now;
                        pend_valid_next = 1'b1;
                        pend_prim_next  = 1'b1;
                        pend_id_next    = 32'd0;
                    end
                end
            end
            stb_pkg::ST_READ: begin
            end
            stb_pkg::ST_EVAL: begin
                unique case (cur_reg.op)
                    stb_pkg::CMD_TICK: begin
                        if (slot_active && went_back) begin
                            mem_we              = 1'b1;
                            mem_wdata.last_tick = cur_reg.now;
                        end else if (slot_fire && !fire_stall) begin
                            mem_we              = 1'b1;
                            mem_wdata.last_tick = cur_reg.now;
                            // Send the held result on and hold this one
                            if (pend_valid_reg) begin
                                out_valid_next = 1'b1;
                                out_next = '{fired: 1'b1, primary_fired: pend_prim_reg,
                                             fired_id: pend_id_reg, ok: 1'b0, last: 1'b0};
                            end
                            pend_valid_next = 1'b1;
                            pend_prim_next  = 1'b0;
                            pend_id_next    = entry.id;
                        end
                    end
                    stb_pkg::CMD_SET: begin
                        if (id_match || free_hit) begin
                            tgt_next   = idx_reg;
                            found_next = 1'b1;
                        end
                    end
                    stb_pkg::CMD_KILL: begin
                        if (id_match) begin
                            valid_clr = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (!fire_stall && !last_slot
                    && !(cur_reg.op == stb_pkg::CMD_SET && id_match)) begin
                    idx_next = idx_reg + stb_pkg::SLOT_W'(1);
                end
            end
            stb_pkg::ST_WRITE: begin
                mem_we        = 1'b1;
                mem_waddr     = tgt_reg;
                mem_wdata     = '{id: cur_reg.timer_id, interval: cur_reg.elapse,
                                  last_tick: cur_reg.now, handler: cur_reg.handler};
                valid_set     = 1'b1;
                reply_ok_next = 1'b1;
            end
            stb_pkg::ST_REPLY: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next = '{fired: 1'b0, primary_fired: 1'b0, fired_id: 32'd0,
                                 ok: reply_ok_reg, last: 1'b1};
                end
            end
            stb_pkg::ST_FINISH: begin
                // Close the tick with the held result or a quiet one
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    out_next = '{fired: pend_valid_reg, primary_fired: pend_valid_reg && pend_prim_reg,
                                 fired_id: pend_valid_reg ? pend_id_reg : 32'd0,
                                 ok: 1'b0, last: 1'b1};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= stb_pkg::ST_IDLE;
            pend_valid_reg <= 1'b0;
            prim_int_reg   <= 32'd0;
            prim_last_reg  <= 32'd0;
            prim_en_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            prim_int_reg   <= prim_int_next;
            prim_last_reg  <= prim_last_next;
            prim_en_reg    <= prim_en_next;
            out_valid_reg  <= out_valid_next;
            found_reg      <= found_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        idx_reg       <= idx_next;
        tgt_reg       <= tgt_next;
        reply_ok_reg  <= reply_ok_next;
        pend_prim_reg <= pend_prim_next;
        pend_id_reg   <= pend_id_next;
        out_reg       <= out_next;
    end

    // Slot valid bits: an entry that is not valid reads as a free slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
        end else begin
            if (valid_set) begin
                slot_valid_reg[mem_waddr] <= 1'b1;
            end
            if (valid_clr) begin
                slot_valid_reg[idx_reg] <= 1'b0;
            end
        end
    end

    // Slot memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg  <= mem[idx_reg];
        rd_valid_reg <= slot_valid_reg[idx_reg];
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    `STB_ASSERT(a_pend_idle, (state_reg == stb_pkg::ST_IDLE) |-> !pend_valid_reg, "held result in idle")
    `STB_ASSERT(a_pop_idle, q_pop |-> (state_reg == stb_pkg::ST_IDLE && q_valid), "pop outside idle")
    `STB_ASSERT(a_we_state, mem_we |-> (state_reg == stb_pkg::ST_EVAL || state_reg == stb_pkg::ST_WRITE), "stray slot write")
    `STB_ASSERT(a_set_valid, (state_reg == stb_pkg::ST_WRITE) |=> slot_valid_reg[$past(tgt_reg)], "loaded slot not valid")

endmodule

// ===== rtl/software_timer_bank.sv =====
// Top level of the software timer bank: front queue plus slot walker.
// Depends on stb_pkg, stb_front and stb_back.
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   command, now, timer_id, elapse, has_handler
//   m_        out        m_valid / m_ready   fired, primary_fired, fired_id, ok, last
//
// A tick checks the primary timer and then walks every slot, and output stalls can hold it: the back
// end reads and then evaluates one slot at a time through the slot memory port.
// A kill walks every slot; a set walks the slots but stops early when the id is found,
// then writes its slot; a refused set or set primary goes straight to its reply.
// Reset is synchronous and active low; slot valid bits clear at once, no sweep.
// A two-item queue takes new items while the back end works or the output stalls.
// A stalled output holds the walk only when another fired result must leave.

module software_timer_bank (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_now,
    input  logic [31:0] s_timer_id,
    input  logic [31:0] s_elapse,
    input  logic        s_has_handler,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_fired,
    output logic        m_primary_fired,
    output logic [31:0] m_fired_id,
    output logic        m_ok,
    output logic        m_last
);

    logic               q_valid;
    logic               q_pop;
    stb_pkg::item_t     q_item;
    stb_pkg::result_t   result;

    stb_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_now         (s_now),
        .s_timer_id    (s_timer_id),
        .s_elapse      (s_elapse),
        .s_has_handler (s_has_handler),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    stb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    // Split the result item onto its ports
    assign m_fired         = result.fired;
    assign m_primary_fired = result.primary_fired;
    assign m_fired_id      = result.fired_id;
    assign m_ok            = result.ok;
    assign m_last          = result.last;

endmodule
